// ===== hw/rtl/stwd_pkg.sv =====
// Shared constants and types for the stick-to-wheel detent block.
`timescale 1ns / 1ps

package stwd_pkg;

    localparam int NUM_PADS  = 4;
    localparam int FRAC_BITS = 16;

    localparam int RAW_W   = 16;
    localparam int MAG_W   = RAW_W - 1;
    localparam int EXC_W   = MAG_W + 2;
    localparam int SQ_W    = 2 * EXC_W;
    localparam int DEF_W   = FRAC_BITS + 1;
    localparam int RATE_W  = 10;
    localparam int SCALED_W = FRAC_BITS + 6;
    localparam int SUM_W   = FRAC_BITS + 7;
    localparam int CARRY_W = FRAC_BITS + 1;
    localparam int WHOLE_W = SUM_W - 1 - FRAC_BITS;
    localparam int OUT_W   = WHOLE_W + 1;
    localparam int EST_W   = SQ_W + DEF_W;

    localparam int ACNT_W = $clog2(SCALED_W);

    localparam int RECIP_SHIFT = 34;

    localparam logic [MAG_W-1:0]  AXIS_FULL       = 15'd32767;
    localparam logic [SQ_W-1:0]   DEFLECT_DEN     = 34'd9663086601;
    // floor(2^(RECIP_SHIFT + FRAC_BITS) / DEFLECT_DEN)
    localparam logic [DEF_W-1:0]  DEFLECT_RECIP   = 17'd116515;
    localparam logic [5:0]        DETENTS_PER_SEC = 6'd48;
    localparam logic [RATE_W-1:0] DEFAULT_RATE    = 10'd60;
    localparam logic signed [OUT_W-1:0] MAX_DETENTS = 7'sd48;

    typedef struct packed {
        logic             neg;
        logic [DEF_W-1:0] mag;
    } t_deflect;

    typedef struct packed {
        logic     done;
        t_deflect pushed;
    } t_lane_res;

endpackage

// ===== hw/rtl/stwd_pad_lane.sv =====
// One pad lane: dead zone, square and constant-divisor scaling of both axes.
`timescale 1ns / 1ps

module stwd_pad_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_present,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_raw_x,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_raw_y,
    output stwd_pkg::t_lane_res                  o_res
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_SQ   = 3'd1;
    localparam logic [2:0] L_EST  = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_FIX  = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic                          r_done, n_done;
    logic                          r_present;

    logic [stwd_pkg::RAW_W-1:0]    w_raw [2];
    logic [stwd_pkg::DEF_W-1:0]    w_q   [2];
    logic                          w_neg [2];
    logic [stwd_pkg::EST_W-1:0]    w_rem [2];
    logic                          w_x_wins;

    assign w_raw[0] = i_raw_x;
    assign w_raw[1] = i_raw_y;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = L_SQ;
                end
            end
            L_SQ: begin
                n_state = L_EST;
            end
            L_EST: begin
                n_state = L_MUL;
            end
            L_MUL: begin
                n_state = L_FIX;
            end
            L_FIX: begin
                n_state = L_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_present <= i_present;
        end
    end

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic [stwd_pkg::RAW_W-1:0] w_neg_raw;
        logic [stwd_pkg::MAG_W-1:0] w_mag;
        logic [stwd_pkg::EXC_W-1:0] w_quad;
        logic [stwd_pkg::EXC_W-1:0] n_e;
        logic [stwd_pkg::SQ_W-1:0]  w_sq;
        logic [stwd_pkg::EST_W-1:0] w_est;
        logic [stwd_pkg::EST_W-1:0] w_t;
        logic [stwd_pkg::EST_W-1:0] w_num;
        logic                       w_fix;
        logic [stwd_pkg::EXC_W-1:0] r_e;
        logic                       r_neg;
        logic [stwd_pkg::SQ_W-1:0]  r_sq;
        logic [stwd_pkg::EST_W-1:0] r_t;
        logic [stwd_pkg::DEF_W-1:0] r_q;

        always_comb begin
            w_neg_raw = ~w_raw[a] + 1'b1;
            if (!w_raw[a][stwd_pkg::RAW_W-1]) begin
                w_mag = w_raw[a][stwd_pkg::MAG_W-1:0];
            end else if (w_raw[a][stwd_pkg::MAG_W-1:0] == '0) begin
                w_mag = stwd_pkg::AXIS_FULL;
            end else begin
                w_mag = w_neg_raw[stwd_pkg::MAG_W-1:0];
            end
            w_quad = {w_mag, 2'b00};
            if (w_quad > stwd_pkg::EXC_W'(stwd_pkg::AXIS_FULL)) begin
                n_e = w_quad - stwd_pkg::EXC_W'(stwd_pkg::AXIS_FULL);
            end else begin
                n_e = '0;
            end
        end

        assign w_sq  = r_e * r_e;
        assign w_est = stwd_pkg::EST_W'(r_sq) * stwd_pkg::EST_W'(stwd_pkg::DEFLECT_RECIP);
        assign w_t   = stwd_pkg::EST_W'(r_q) * stwd_pkg::EST_W'(stwd_pkg::DEFLECT_DEN);
        assign w_num = stwd_pkg::EST_W'({r_sq, {stwd_pkg::FRAC_BITS{1'b0}}});
        assign w_fix = w_num >= r_t + stwd_pkg::EST_W'(stwd_pkg::DEFLECT_DEN);

        always_ff @(posedge i_clk) begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_e   <= n_e;
                        r_neg <= w_raw[a][stwd_pkg::RAW_W-1];
                    end
                end
                L_SQ: begin
                    r_sq <= w_sq;
                end
                L_EST: begin
                    r_q <= w_est[stwd_pkg::RECIP_SHIFT + stwd_pkg::DEF_W - 1:
                                 stwd_pkg::RECIP_SHIFT];
                end
                L_MUL: begin
                    r_t <= w_t;
                end
                L_FIX: begin
                    r_q <= r_q + stwd_pkg::DEF_W'(w_fix);
                end
                default: begin
                end
            endcase
        end

        assign w_q[a]   = r_q;
        assign w_neg[a] = r_neg;
        assign w_rem[a] = w_num - r_t;
    end

    assign w_x_wins = w_q[0] >= w_q[1];

    always_comb begin
        o_res.done = r_done;
        if (!r_present) begin
            o_res.pushed = '0;
        end else if (w_x_wins) begin
            o_res.pushed.neg = w_neg[0];
            o_res.pushed.mag = w_q[0];
        end else begin
            o_res.pushed.neg = w_neg[1];
            o_res.pushed.mag = w_q[1];
        end
    end

`ifndef SYNTH
    a_estimate_one_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == L_FIX |->
            (w_rem[0] < (stwd_pkg::EST_W'(stwd_pkg::DEFLECT_DEN) << 1) &&
             w_rem[1] < (stwd_pkg::EST_W'(stwd_pkg::DEFLECT_DEN) << 1)))
        else $error("lane scaling estimate off by more than one");
`endif

endmodule

// ===== hw/rtl/stwd_merge.sv =====
// Merge stage: picks the strongest pad deflection, lowest pad on ties.
`timescale 1ns / 1ps

module stwd_merge (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  stwd_pkg::t_lane_res [stwd_pkg::NUM_PADS-1:0] i_lanes,
    output logic                                         o_valid,
    output stwd_pkg::t_deflect                           o_strongest
);

    stwd_pkg::t_deflect              n_best;
    stwd_pkg::t_deflect              r_best;
    logic                            r_valid;
    logic [stwd_pkg::NUM_PADS-1:0]   w_done;

    always_comb begin
        n_best = '0;
        for (int p = 0; p < stwd_pkg::NUM_PADS; p++) begin
            w_done[p] = i_lanes[p].done;
            if (i_lanes[p].pushed.mag > n_best.mag) begin
                n_best = i_lanes[p].pushed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_lanes[0].done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lanes[0].done) begin
            r_best <= n_best;
        end
    end

    assign o_valid     = r_valid;
    assign o_strongest = r_best;

`ifndef SYNTH
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done == '0 || w_done == '1))
        else $error("pad lanes finished out of step");
`endif

endmodule

// ===== hw/rtl/stwd_detent_acc.sv =====
// Rate divider, fractional carry and output register for the detent count.
`timescale 1ns / 1ps

module stwd_detent_acc (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [stwd_pkg::RATE_W-1:0]          i_frame_rate,
    input  logic                                 i_start,
    input  stwd_pkg::t_deflect                   i_strongest,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [stwd_pkg::OUT_W-1:0]    o_detents,
    output logic                                 o_done
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_SUM  = 2'd2;
    localparam logic [1:0] A_PUT  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [stwd_pkg::ACNT_W-1:0]         r_cnt, n_cnt;
    logic                                r_out_valid;
    logic signed [stwd_pkg::OUT_W-1:0]   r_detents;
    logic signed [stwd_pkg::CARRY_W-1:0] r_carry;

    logic [stwd_pkg::SCALED_W-1:0]       r_num;
    logic [stwd_pkg::RATE_W-1:0]         r_rem;
    logic [stwd_pkg::RATE_W-1:0]         r_div;
    logic                                r_neg;
    logic signed [stwd_pkg::SUM_W-1:0]   r_sum;

    logic [stwd_pkg::SCALED_W-1:0]       n_num;
    logic [stwd_pkg::RATE_W:0]           w_trial;
    logic [stwd_pkg::RATE_W:0]           w_diff;
    logic                                w_ge;
    logic [stwd_pkg::RATE_W-1:0]         n_rem;
    logic signed [stwd_pkg::SUM_W-1:0]   w_inc_ext;
    logic signed [stwd_pkg::SUM_W-1:0]   w_carry_ext;
    logic signed [stwd_pkg::SUM_W-1:0]   n_sum;
    logic                                w_sum_neg;
    logic [stwd_pkg::SUM_W-1:0]          w_sum_abs;
    logic [stwd_pkg::WHOLE_W-1:0]        w_whole;
    logic [stwd_pkg::OUT_W-1:0]          w_whole_ext;
    logic [stwd_pkg::CARRY_W-1:0]        w_frac_ext;
    logic signed [stwd_pkg::OUT_W-1:0]   n_detents;
    logic signed [stwd_pkg::CARRY_W-1:0] n_carry;
    logic                                w_free;

    assign n_num   = stwd_pkg::SCALED_W'(i_strongest.mag) *
                     stwd_pkg::SCALED_W'(stwd_pkg::DETENTS_PER_SEC);
    assign w_trial = {r_rem, r_num[stwd_pkg::SCALED_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[stwd_pkg::RATE_W-1:0] : w_trial[stwd_pkg::RATE_W-1:0];

    assign w_inc_ext   = {1'b0, r_num};
    assign w_carry_ext = {{(stwd_pkg::SUM_W - stwd_pkg::CARRY_W){r_carry[stwd_pkg::CARRY_W-1]}},
                          r_carry};
    assign n_sum       = w_carry_ext + (r_neg ? -w_inc_ext : w_inc_ext);

    assign w_sum_neg   = r_sum[stwd_pkg::SUM_W-1];
    assign w_sum_abs   = w_sum_neg ? -r_sum : r_sum;
    assign w_whole     = w_sum_abs[stwd_pkg::SUM_W-2:stwd_pkg::FRAC_BITS];
    assign w_whole_ext = {1'b0, w_whole};
    assign w_frac_ext  = {1'b0, w_sum_abs[stwd_pkg::FRAC_BITS-1:0]};
    assign n_detents   = w_sum_neg ? -w_whole_ext : w_whole_ext;
    assign n_carry     = w_sum_neg ? -w_frac_ext : w_frac_ext;

    assign w_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_done  = 1'b0;
        unique case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    n_cnt   = '0;
                    n_state = (i_strongest.mag == '0) ? A_PUT : A_DIV;
                end
            end
            A_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == stwd_pkg::ACNT_W'(stwd_pkg::SCALED_W - 1)) begin
                    n_state = A_SUM;
                end
            end
            A_SUM: begin
                n_state = A_PUT;
            end
            A_PUT: begin
                if (w_free) begin
                    n_state = A_IDLE;
                    o_done  = 1'b1;
                end
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= A_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_carry     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_done) begin
                r_out_valid <= 1'b1;
                r_carry     <= n_carry;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    r_num <= n_num;
                    r_rem <= '0;
                    r_div <= (i_frame_rate == '0) ? stwd_pkg::DEFAULT_RATE : i_frame_rate;
                    r_neg <= i_strongest.neg;
                    r_sum <= '0;
                end
            end
            A_DIV: begin
                r_rem <= n_rem;
                r_num <= {r_num[stwd_pkg::SCALED_W-2:0], w_ge};
            end
            A_SUM: begin
                r_sum <= n_sum;
            end
            A_PUT: begin
                if (w_free) begin
                    r_detents <= n_detents;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_detents   = r_detents;

`ifndef SYNTH
    a_carry_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_carry != {1'b1, {(stwd_pkg::CARRY_W-1){1'b0}}})
        else $error("detent carry reached a whole detent");
    a_detents_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_detents <= stwd_pkg::MAX_DETENTS &&
                         o_detents >= -stwd_pkg::MAX_DETENTS))
        else $error("detent count out of range");
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> o_out_valid)
        else $error("finished item missing from output register");
`endif

endmodule

// ===== hw/rtl/stick_to_wheel_detents_top.sv =====
// Stick-to-wheel detents top level. Each accepted item is one frame tick with
// up to four pads of X/Y stick readings; the block removes a quarter dead zone,
// applies a squared response, keeps the strongest deflection of all present
// pads and turns it into whole wheel detents at 48 per second for the frame
// rate in the frame_rate register (0 selects 60), carrying the fraction over
// to the next tick. A tick with no deflection clears the carry. One item is
// in flight at a time: the next tick is taken only after the last has passed
// the square, estimate, multiply and fix steps of each pad lane, the merge
// register, the bit-serial frame rate divider (FRAC_BITS + 6 steps) and the
// sum step (these two are skipped when every stick is in its dead zone or no
// pad is present). The finished count waits in an output register, so the
// result can sit unread while the next tick is already being worked on; a
// second result stalls until that register is read. Write frame_rate only
// while no item is in flight.
`timescale 1ns / 1ps

module stick_to_wheel_detents_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stwd_pkg::RATE_W-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [stwd_pkg::NUM_PADS-1:0]        i_pad_present,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_x_0,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_y_0,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_x_1,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_y_1,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_x_2,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_y_2,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_x_3,
    input  logic signed [stwd_pkg::RAW_W-1:0]    i_stick_y_3,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [stwd_pkg::OUT_W-1:0]    o_detents
);

    logic [stwd_pkg::RATE_W-1:0]                 r_frame_rate;
    logic                                        r_busy;
    logic                                        w_accept;
    logic                                        w_acc_done;
    logic                                        w_merge_valid;
    stwd_pkg::t_deflect                          w_strongest;
    stwd_pkg::t_lane_res [stwd_pkg::NUM_PADS-1:0] w_lanes;
    logic signed [stwd_pkg::RAW_W-1:0]           w_raw_x [stwd_pkg::NUM_PADS];
    logic signed [stwd_pkg::RAW_W-1:0]           w_raw_y [stwd_pkg::NUM_PADS];

    assign w_raw_x[0] = i_stick_x_0;
    assign w_raw_y[0] = i_stick_y_0;
    assign w_raw_x[1] = i_stick_x_1;
    assign w_raw_y[1] = i_stick_y_1;
    assign w_raw_x[2] = i_stick_x_2;
    assign w_raw_y[2] = i_stick_y_2;
    assign w_raw_x[3] = i_stick_x_3;
    assign w_raw_y[3] = i_stick_y_3;

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= '0;
            r_busy       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_rate <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_acc_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    for (genvar p = 0; p < stwd_pkg::NUM_PADS; p++) begin : g_lane
        stwd_pad_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_accept),
            .i_present (i_pad_present[p]),
            .i_raw_x   (w_raw_x[p]),
            .i_raw_y   (w_raw_y[p]),
            .o_res     (w_lanes[p])
        );
    end

    stwd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lanes     (w_lanes),
        .o_valid     (w_merge_valid),
        .o_strongest (w_strongest)
    );

    stwd_detent_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_rate (r_frame_rate),
        .i_start      (w_merge_valid),
        .i_strongest  (w_strongest),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_detents    (o_detents),
        .o_done       (w_acc_done)
    );

`ifndef SYNTH
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_done || w_merge_valid) |-> r_busy)
        else $error("item finished with no item in flight");
`endif

endmodule
